FILE: rtl/cci_pkg.sv
// Package for the commodity channel index unit: field widths, result limits,
// scale constants and sequencer states. No dependencies.
`timescale 1ns / 1ps

package cci_pkg;

    // field widths
    localparam int PRICE_W = 24;
    localparam int TYP_W   = 26;   // high + low + close
    localparam int CCI_W   = 23;
    localparam int BARS_W  = 9;

    // parameter defaults
    localparam int DEFAULT_MAX_BARS  = 256;
    localparam int DEFAULT_FRAC_BITS = 8;

    // cci = (T_last - mean) * n * 1000 / (15 * S), i.e. divide by 0.015 * S / n
    localparam int CCI_SCALE_NUM = 1000;
    localparam int CCI_SCALE_DEN = 15;

    // saturation limits of the signed result
    localparam logic [CCI_W-1:0] CCI_MAG_CAP = 23'd4194304;
    localparam logic [CCI_W-1:0] CCI_POS_MAX = 23'd4194303;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN,
        ST_DEV,
        ST_DRAIN,
        ST_MUL1,
        ST_MUL2,
        ST_CDIV,
        ST_FINISH
    } cci_state_t;

endpackage

FILE: rtl/commodity_channel_index_unit.sv
// Commodity channel index unit: bar store, running total, shared restoring
// divider and a small sequencer. Depends on cci_pkg.
`timescale 1ns / 1ps

//  channel | ports                               | direction | request
//  --------+-------------------------------------+-----------+------------------------
//  s_      | bar_high, bar_low, bar_close, last  | in        | one price bar
//  m_      | cci_value, bars_used, dev_zero, ovf | out       | one cci per set of bars
//
//  A bar without the last mark is stored at once if the store has room, else dropped.
//  A last bar starts the evaluation: mean division, one pass over the n stored
//  bars, two multiply steps and the cci division (a zero deviation skips the
//  second multiply step and the cci division); DVD_W = 36 + clog2(MAX_BARS+1)
//  + FRAC_BITS (53 at defaults). Both divisions run on the one shared divider.
//  s_ready is low during the evaluation; a result waiting on m_ready stalls only
//  the final load of the output register. Reset is synchronous, active low.
module commodity_channel_index_unit
    import cci_pkg::*;
#(
    parameter int MAX_BARS  = DEFAULT_MAX_BARS,
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // bar requests
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [PRICE_W-1:0]         s_bar_high,
    input  logic [PRICE_W-1:0]         s_bar_low,
    input  logic [PRICE_W-1:0]         s_bar_close,
    input  logic                       s_last_bar,
    // result requests
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [CCI_W-1:0]    m_cci_value,
    output logic [BARS_W-1:0]          m_bars_used,
    output logic                       m_deviation_zero,
    output logic                       m_too_many_bars
);

    localparam int CNT_W   = $clog2(MAX_BARS + 1);
    localparam int ADDR_W  = $clog2(MAX_BARS);
    localparam int TOTAL_W = TYP_W + CNT_W;
    localparam int DEV_W   = TYP_W + CNT_W;
    localparam int DEN_W   = DEV_W + 4;          // times 15
    localparam int P1_W    = TYP_W + CNT_W;
    localparam int NUM_W   = P1_W + 10;          // times 1000
    localparam int DVD_W   = NUM_W + FRAC_BITS;
    localparam int DCNT_W  = $clog2(DVD_W);
    localparam int QUO_W   = TYP_W;

    cci_state_t state_reg, state_next;

    logic [CNT_W-1:0]   bar_count_reg, bar_count_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               ovf_seen_reg, ovf_seen_next;
    logic               m_valid_reg, m_valid_next;

    logic [CNT_W-1:0]   n_reg, n_next;
    logic               set_ovf_reg, set_ovf_next;
    logic [TYP_W-1:0]   mean_reg, mean_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [TYP_W-1:0]   rd_data_reg;
    logic [DEV_W-1:0]   dev_reg, dev_next;
    logic [TYP_W-1:0]   t_last_reg, t_last_next;
    logic               neg_reg, neg_next;
    logic               dz_reg, dz_next;
    logic [P1_W-1:0]    p1_reg, p1_next;

    // shared divider
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [DEN_W-1:0]   dvs_reg, dvs_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   quot_reg, quot_next;
    logic               sticky_reg, sticky_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;

    logic signed [CCI_W-1:0] cci_reg, cci_next;
    logic [BARS_W-1:0]  bars_reg, bars_next;
    logic               dzo_reg, dzo_next;
    logic               ovo_reg, ovo_next;

    logic [TYP_W-1:0]   store_mem [MAX_BARS];
    logic [ADDR_W-1:0]  rd_addr;

    logic               s_fire;
    logic               room;
    logic [TYP_W-1:0]   typ;
    logic [CNT_W-1:0]   count_after;
    logic [TOTAL_W-1:0] total_after;

    logic [DEN_W:0]     rem_shift;
    logic [DEN_W:0]     rem_sub;
    logic               div_ge;
    logic [TYP_W-1:0]   abs_dev;
    logic [TYP_W-1:0]   diff;
    logic [CCI_W-1:0]   mag;

    // bar intake
    assign s_fire      = s_valid && s_ready;
    assign room        = bar_count_reg < CNT_W'(MAX_BARS);
    assign typ         = TYP_W'(s_bar_high) + TYP_W'(s_bar_low) + TYP_W'(s_bar_close);
    assign count_after = room ? bar_count_reg + CNT_W'(1) : bar_count_reg;
    assign total_after = room ? total_reg + TOTAL_W'(typ) : total_reg;
    assign rd_addr     = rd_idx_reg[ADDR_W-1:0];

    // one restoring step of the shared divider
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};
    assign div_ge    = rem_shift >= {1'b0, dvs_reg};

    // deviation of the bar coming out of the store
    assign abs_dev = (rd_data_reg >= mean_reg) ? rd_data_reg - mean_reg
                                               : mean_reg - rd_data_reg;
    assign diff    = neg_reg ? mean_reg - t_last_reg : t_last_reg - mean_reg;

    // quotient magnitude capped at the negative range end
    assign mag = (sticky_reg || quot_reg > QUO_W'(CCI_MAG_CAP)) ? CCI_MAG_CAP
                                                                : quot_reg[CCI_W-1:0];

    // bar store, one write and one registered read
    always_ff @(posedge aclk) begin
        if (s_fire && room) begin
            store_mem[bar_count_reg[ADDR_W-1:0]] <= typ;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            bar_count_reg <= '0;
            total_reg     <= '0;
            ovf_seen_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bar_count_reg <= bar_count_next;
            total_reg     <= total_next;
            ovf_seen_reg  <= ovf_seen_next;
            m_valid_reg   <= m_valid_next;
            rd_pend_reg   <= rd_pend_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        set_ovf_reg <= set_ovf_next;
        mean_reg    <= mean_next;
        rd_idx_reg  <= rd_idx_next;
        dev_reg     <= dev_next;
        t_last_reg  <= t_last_next;
        neg_reg     <= neg_next;
        dz_reg      <= dz_next;
        p1_reg      <= p1_next;
        dvd_reg     <= dvd_next;
        dvs_reg     <= dvs_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        sticky_reg  <= sticky_next;
        dcnt_reg    <= dcnt_next;
        cci_reg     <= cci_next;
        bars_reg    <= bars_next;
        dzo_reg     <= dzo_next;
        ovo_reg     <= ovo_next;
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        bar_count_next = bar_count_reg;
        total_next     = total_reg;
        ovf_seen_next  = ovf_seen_reg;
        m_valid_next   = m_valid_reg;
        n_next         = n_reg;
        set_ovf_next   = set_ovf_reg;
        mean_next      = mean_reg;
        rd_idx_next    = rd_idx_reg;
        rd_pend_next   = 1'b0;
        dev_next       = dev_reg;
        t_last_next    = t_last_reg;
        neg_next       = neg_reg;
        dz_next        = dz_reg;
        p1_next        = p1_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        sticky_next    = sticky_reg;
        dcnt_next      = dcnt_reg;
        cci_next       = cci_reg;
        bars_next      = bars_reg;
        dzo_next       = dzo_reg;
        ovo_next       = ovo_reg;
        s_ready        = 1'b0;

        // result taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                // ready is high here, so valid alone means a request is taken
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_last_bar) begin
                        // latch the set, clear the running state, start mean division
                        n_next         = count_after;
                        set_ovf_next   = ovf_seen_reg || !room;
                        bar_count_next = '0;
                        total_next     = '0;
                        ovf_seen_next  = 1'b0;
                        dvd_next       = DVD_W'(total_after);
                        dvs_next       = DEN_W'(count_after);
                        rem_next       = '0;
                        quot_next      = '0;
                        sticky_next    = 1'b0;
                        dcnt_next      = '0;
                        state_next     = ST_MEAN;
                    end else begin
                        bar_count_next = count_after;
                        total_next     = total_after;
                        ovf_seen_next  = ovf_seen_reg || !room;
                    end
                end
            end

            ST_MEAN, ST_CDIV: begin
                // one quotient bit a cycle
                dvd_next    = dvd_reg << 1;
                rem_next    = div_ge ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
                quot_next   = {quot_reg[QUO_W-2:0], div_ge};
                sticky_next = sticky_reg || quot_reg[QUO_W-1];
                dcnt_next   = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(DVD_W - 1)) begin
                    if (state_reg == ST_MEAN) begin
                        mean_next   = quot_next;
                        rd_idx_next = '0;
                        dev_next    = '0;
                        state_next  = ST_DEV;
                    end else begin
                        state_next  = ST_FINISH;
                    end
                end
            end

            ST_DEV: begin
                // stream the stored bars, accumulate each deviation in the cycle after its read
                rd_pend_next = 1'b1;
                if (rd_pend_reg) begin
                    dev_next = dev_reg + DEV_W'(abs_dev);
                end
                if (rd_idx_reg == n_reg - CNT_W'(1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
            end

            ST_DRAIN: begin
                // last read is the newest bar of the set
                dev_next    = dev_reg + DEV_W'(abs_dev);
                t_last_next = rd_data_reg;
                neg_next    = rd_data_reg < mean_reg;
                state_next  = ST_MUL1;
            end

            ST_MUL1: begin
                p1_next  = P1_W'(diff) * P1_W'(n_reg);
                dvs_next = DEN_W'(dev_reg) * DEN_W'(CCI_SCALE_DEN);
                dz_next  = dev_reg == '0;
                if (dev_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_MUL2;
                end
            end

            ST_MUL2: begin
                dvd_next    = DVD_W'(NUM_W'(p1_reg) * NUM_W'(CCI_SCALE_NUM)) << FRAC_BITS;
                rem_next    = '0;
                quot_next   = '0;
                sticky_next = 1'b0;
                dcnt_next   = '0;
                state_next  = ST_CDIV;
            end

            ST_FINISH: begin
                // load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    if (dz_reg) begin
                        cci_next = '0;
                    end else if (neg_reg) begin
                        cci_next = -$signed(mag);
                    end else if (mag > CCI_POS_MAX) begin
                        cci_next = $signed(CCI_POS_MAX);
                    end else begin
                        cci_next = $signed(mag);
                    end
                    bars_next    = BARS_W'(n_reg);
                    dzo_next     = dz_reg;
                    ovo_next     = set_ovf_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_cci_value      = cci_reg;
    assign m_bars_used      = bars_reg;
    assign m_deviation_zero = dzo_reg;
    assign m_too_many_bars  = ovo_reg;

    // the set never grows past capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bar_count_reg <= CNT_W'(MAX_BARS))
        else $error("bar count beyond capacity");

    // a last bar closes intake until the result is formed
    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_bar) |=> !s_ready)
        else $error("bar accepted during evaluation");

    // the deviation pass stays inside the set
    a_read_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEV) |-> (rd_idx_reg < n_reg))
        else $error("store read past the set");

    // a result appears only from the finishing step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result without evaluation");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for commodity_channel_index_unit: drives price bars in sets,
// predicts each set's CCI result on its own and compares every result field.
// Depends on cci_pkg and the commodity_channel_index_unit RTL.
`timescale 1ns / 1ps

module tb_top
    import cci_pkg::*;
();

    localparam int MAX_BARS     = DEFAULT_MAX_BARS;
    localparam int FRAC_BITS    = DEFAULT_FRAC_BITS;
    localparam int DVD_W        = 36 + $clog2(MAX_BARS + 1) + FRAC_BITS;
    localparam int DRAIN_CYCLES = 2 * DVD_W + MAX_BARS + 16;
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_BARS  = 130;
    localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

    typedef struct packed {
        logic [CCI_W-1:0]  cci;
        logic [BARS_W-1:0] bars;
        logic              dev_zero;
        logic              too_many;
    } cci_result_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [PRICE_W-1:0]        s_bar_high;
    logic [PRICE_W-1:0]        s_bar_low;
    logic [PRICE_W-1:0]        s_bar_close;
    logic                      s_last_bar;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [CCI_W-1:0]   m_cci_value;
    logic [BARS_W-1:0]         m_bars_used;
    logic                      m_deviation_zero;
    logic                      m_too_many_bars;

    // predictor state: typical sums of the open set
    logic [TYP_W-1:0]  typical_sums [0:MAX_BARS-1];
    int unsigned       held_bars;
    longint unsigned   typical_running;
    bit                bars_dropped;
    cci_result_t       cci_expected [$];

    // run statistics
    int unsigned bars_sent;
    int unsigned sets_sent;
    int unsigned results_checked;
    int unsigned mismatches;
    int unsigned zero_dev_sets;
    int unsigned overfull_sets;
    int unsigned saturated_sets;
    int unsigned idle_cycles;
    bit          tx_no_idle;

    commodity_channel_index_unit uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_bar_high       (s_bar_high),
        .s_bar_low        (s_bar_low),
        .s_bar_close      (s_bar_close),
        .s_last_bar       (s_last_bar),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cci_value      (m_cci_value),
        .m_bars_used      (m_bars_used),
        .m_deviation_zero (m_deviation_zero),
        .m_too_many_bars  (m_too_many_bars)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // update the set state with one accepted bar; close the set on the last mark
    task automatic predict_cci_bar(input logic [PRICE_W-1:0] hi, input logic [PRICE_W-1:0] lo,
                                   input logic [PRICE_W-1:0] cl, input logic last);
        logic [TYP_W-1:0] typ;
        longint unsigned  mean;
        longint unsigned  dev_sum;
        longint unsigned  t_last;
        longint unsigned  diff;
        longint unsigned  mag;
        bit               neg;
        int unsigned      i;
        cci_result_t      res;
        typ = TYP_W'(hi) + TYP_W'(lo) + TYP_W'(cl);
        if (held_bars < MAX_BARS) begin
            typical_sums[held_bars] = typ;
            held_bars++;
            typical_running += typ;
        end else begin
            bars_dropped = 1'b1;
        end
        if (last) begin
            res = '0;
            res.bars = BARS_W'(held_bars);
            mean = typical_running / held_bars;
            dev_sum = 0;
            for (i = 0; i < held_bars; i++) begin
                dev_sum += (typical_sums[i] >= mean) ? (typical_sums[i] - mean)
                                                     : (mean - typical_sums[i]);
            end
            if (dev_sum == 0) begin
                res.dev_zero = 1'b1;
                zero_dev_sets++;
            end else begin
                t_last = typical_sums[held_bars - 1];
                neg = t_last < mean;
                diff = neg ? (mean - t_last) : (t_last - mean);
                // truncated scaled quotient, capped at the negative range end
                mag = ((diff * held_bars * CCI_SCALE_NUM) << FRAC_BITS)
                      / (dev_sum * CCI_SCALE_DEN);
                if (mag > CCI_MAG_CAP) begin
                    mag = CCI_MAG_CAP;
                end
                if (neg) begin
                    res.cci = CCI_W'(64'd0 - mag);
                end else if (mag > CCI_POS_MAX) begin
                    res.cci = CCI_POS_MAX;
                    saturated_sets++;
                end else begin
                    res.cci = CCI_W'(mag);
                end
            end
            res.too_many = bars_dropped;
            if (bars_dropped) begin
                overfull_sets++;
            end
            cci_expected.push_back(res);
            sets_sent++;
            held_bars = 0;
            typical_running = 0;
            bars_dropped = 1'b0;
        end
    endtask

    // send one bar request after a random gap (none when tx_no_idle is set), then update the prediction
    task automatic send_bar(input logic [PRICE_W-1:0] hi, input logic [PRICE_W-1:0] lo,
                            input logic [PRICE_W-1:0] cl, input logic last);
        int unsigned gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_bar_high  <= hi;
        s_bar_low   <= lo;
        s_bar_close <= cl;
        s_last_bar  <= last;
        do @(posedge aclk); while (!s_ready);
        bars_sent++;
        predict_cci_bar(hi, lo, cl, last);
    endtask

    // one-bar sets, extreme prices, signs, flat sets and mean truncation
    task automatic test_directed_sets();
        tx_no_idle = 1'b0;
        send_bar(PRICE_MAX, PRICE_MAX, PRICE_MAX, 1'b1);
        send_bar('0, '0, '0, 1'b1);
        send_bar('0, '0, '0, 1'b0);
        send_bar(PRICE_MAX, PRICE_MAX, PRICE_MAX, 1'b1);
        send_bar(PRICE_MAX, PRICE_MAX, PRICE_MAX, 1'b0);
        send_bar('0, '0, '0, 1'b1);
        send_bar(24'h800000, 24'h7FFFFF, 24'h000100, 1'b0);
        send_bar(24'h800000, 24'h7FFFFF, 24'h000100, 1'b0);
        send_bar(24'h800000, 24'h7FFFFF, 24'h000100, 1'b1);
        send_bar('0, '0, '0, 1'b0);
        send_bar(24'h000001, '0, '0, 1'b1);
        tx_no_idle = 1'b1;
        send_bar(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b0);
        send_bar(24'h555555, 24'hAAAAAA, 24'h555555, 1'b0);
        send_bar(24'hF0F0F0, 24'h0F0F0F, 24'h123456, 1'b0);
        send_bar(24'h0F0F0F, 24'hF0F0F0, 24'hFEDCBA, 1'b1);
        tx_no_idle = 1'b0;
        send_bar(24'd100, 24'd100, 24'd100, 1'b0);
        send_bar(24'd100, 24'd100, 24'd100, 1'b0);
        send_bar('0, '0, 24'd1, 1'b1);
    endtask

    // full set whose newest bar is a tiny outlier, then two bars past capacity;
    // both are dropped, so the outlier closes the set and saturates
    task automatic test_capacity();
        logic [PRICE_W-1:0] base;
        int                 k;
        base = 24'h123456;
        for (k = 0; k < MAX_BARS + 2; k++) begin
            tx_no_idle = (k < 100);
            if (k == MAX_BARS - 1) begin
                send_bar(base + 24'd5, base, base, 1'b0);
            end else begin
                send_bar(base, base, base, k == MAX_BARS + 1);
            end
        end
    endtask

    // random well-formed sets of mixed shape and size
    task automatic test_random_sets(input int unsigned target);
        int unsigned        start_bars;
        int unsigned        set_len;
        int unsigned        style;
        int unsigned        spread;
        int unsigned        k;
        logic [PRICE_W-1:0] base;
        start_bars = bars_sent;
        while (bars_sent - start_bars < target) begin
            style = $urandom_range(0, 3);
            set_len = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
            case ($urandom_range(0, 3))
                0: spread = 1;
                1: spread = 15;
                2: spread = 255;
                default: spread = 4095;
            endcase
            if (style == 0) spread = 32'(PRICE_MAX);
            if (style == 2) spread = 0;
            base = PRICE_W'($urandom_range(0, 32'(PRICE_MAX) - spread));
            tx_no_idle = ($urandom_range(0, 3) == 0);
            for (k = 0; k < set_len; k++) begin
                // outlier style: last bar anywhere in the price range
                if (style == 3 && k == set_len - 1) begin
                    send_bar(PRICE_W'($urandom_range(0, 32'(PRICE_MAX))),
                             PRICE_W'($urandom_range(0, 32'(PRICE_MAX))),
                             PRICE_W'($urandom_range(0, 32'(PRICE_MAX))), 1'b1);
                end else begin
                    send_bar(base + PRICE_W'($urandom_range(0, spread)),
                             base + PRICE_W'($urandom_range(0, spread)),
                             base + PRICE_W'($urandom_range(0, spread)), k == set_len - 1);
                end
            end
        end
    endtask

    // result side: random stall before each result
    initial begin
        int unsigned stall;
        m_ready <= 1'b1;
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // compare each result with the oldest prediction
    initial begin
        cci_result_t want;
        cci_result_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = '{cci: m_cci_value, bars: m_bars_used, dev_zero: m_deviation_zero,
                        too_many: m_too_many_bars};
                if (cci_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected cci result: cci=%0d bars=%0d dz=%0b tm=%0b",
                                 $signed(got.cci), got.bars, got.dev_zero, got.too_many);
                    end
                end else begin
                    want = cci_expected.pop_front();
                    results_checked++;
                    if (got.cci !== want.cci || got.bars !== want.bars
                        || got.dev_zero !== want.dev_zero || got.too_many !== want.too_many) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("cci result %0d wrong: exp cci=%0d bars=%0d dz=%0b tm=%0b",
                                     results_checked, $signed(want.cci), want.bars,
                                     want.dev_zero, want.too_many);
                            $display("    got cci=%0d bars=%0d dz=%0b tm=%0b",
                                     $signed(got.cci), got.bars, got.dev_zero, got.too_many);
                        end
                    end
                end
            end
        end
    end

    // watchdog: ends the run after too long without any handshake
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("commodity_channel_index_unit: mismatch");
        $finish;
    end

    // main sequence
    initial begin
        s_valid         <= 1'b0;
        s_bar_high      <= '0;
        s_bar_low       <= '0;
        s_bar_close     <= '0;
        s_last_bar      <= 1'b0;
        aresetn         <= 1'b0;
        held_bars       = 0;
        typical_running = 0;
        bars_dropped    = 1'b0;
        bars_sent       = 0;
        sets_sent       = 0;
        results_checked = 0;
        mismatches      = 0;
        zero_dev_sets   = 0;
        overfull_sets   = 0;
        saturated_sets  = 0;
        tx_no_idle      = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_sets();
        test_capacity();
        test_random_sets(RANDOM_BARS);
        s_valid <= 1'b0;

        // let the last results drain
        while (cci_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d bars in %0d sets, checked %0d cci results", bars_sent, sets_sent,
                 results_checked);
        $display("flat sets %0d, overfull sets %0d, saturated results %0d, mismatches %0d",
                 zero_dev_sets, overfull_sets, saturated_sets, mismatches);
        if (mismatches == 0 && cci_expected.size() == 0) begin
            $display("commodity_channel_index_unit: match");
        end else begin
            $display("commodity_channel_index_unit: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/cci_pkg.sv
rtl/commodity_channel_index_unit.sv
tb/tb_top.sv
